[rtl/core/rfh_pkg.sv]
// Shared types and constants for the resonant filter, high-pass and amplifier chain.
package rfh_pkg;

  localparam int FRAC_SHIFT = 7;
  localparam logic signed [15:0] CLIP_HIGH = 16'sd127;
  localparam logic signed [15:0] CLIP_LOW  = -16'sd127;

  // Configuration register indexes.
  localparam logic [2:0] CFG_FILTER_MODE = 3'd0;
  localparam logic [2:0] CFG_COEFF_C     = 3'd1;
  localparam logic [2:0] CFG_COEFF_RC    = 3'd2;
  localparam logic [2:0] CFG_HP_CUTOFF   = 3'd3;
  localparam logic [2:0] CFG_AMP_GAIN    = 3'd4;

  // Filter modes; the unused code behaves as bypass.
  localparam logic [1:0] MODE_BYPASS = 2'd0;
  localparam logic [1:0] MODE_RES    = 2'd1;
  localparam logic [1:0] MODE_SIMPLE = 2'd2;

  // Multiplier operand A selects.
  localparam logic [2:0] A_X    = 3'd0;
  localparam logic [2:0] A_S1   = 3'd1;
  localparam logic [2:0] A_S2   = 3'd2;
  localparam logic [2:0] A_HP   = 3'd3;
  localparam logic [2:0] A_DIFF = 3'd4;

  // Multiplier operand B selects.
  localparam logic [2:0] B_C     = 3'd0;
  localparam logic [2:0] B_RC    = 3'd1;
  localparam logic [2:0] B_HPC   = 3'd2;
  localparam logic [2:0] B_HPINV = 3'd3;
  localparam logic [2:0] B_GAIN  = 3'd4;

  // Accumulator operations.
  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;
  localparam logic [1:0] ACC_SUB  = 2'd3;

  // State and output register updates from the shifted accumulator, or from the input sample for UPD_S2_X.
  localparam logic [2:0] UPD_NONE   = 3'd0;
  localparam logic [2:0] UPD_S1_ADD = 3'd1;
  localparam logic [2:0] UPD_S1_SUB = 3'd2;
  localparam logic [2:0] UPD_S2_ADD = 3'd3;
  localparam logic [2:0] UPD_S2_SUB = 3'd4;
  localparam logic [2:0] UPD_S2_X   = 3'd5;
  localparam logic [2:0] UPD_HP     = 3'd6;
  localparam logic [2:0] UPD_OUT    = 3'd7;

  typedef struct packed {
    logic       load_x;
    logic [2:0] a_sel;
    logic [2:0] b_sel;
    logic [1:0] acc_op;
    logic [2:0] upd;
  } rfh_cmd_t;

  localparam rfh_cmd_t CMD_NOP = '{load_x: 1'b0, a_sel: A_X, b_sel: B_C,
                                   acc_op: ACC_HOLD, upd: UPD_NONE};

endpackage

[rtl/core/rfh_ctrl.sv]
// Sequencer that steps the shared multiply-accumulate datapath through one sample.
module rfh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        filter_mode,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output rfh_pkg::rfh_cmd_t cmd
);
  import rfh_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_F0   = 4'd1;
  localparam logic [3:0] ST_F7   = 4'd8;
  localparam logic [3:0] ST_H0   = 4'd9;
  localparam logic [3:0] ST_H1   = 4'd10;
  localparam logic [3:0] ST_H2   = 4'd11;
  localparam logic [3:0] ST_G0   = 4'd12;
  localparam logic [3:0] ST_OUT  = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [3:0] step_full;
  logic [2:0] step;
  rfh_cmd_t   filt_cmd;
  logic       filt_last;

  function automatic rfh_cmd_t mac(logic [2:0] a, logic [2:0] b, logic [1:0] op);
    rfh_cmd_t c;
    c        = CMD_NOP;
    c.a_sel  = a;
    c.b_sel  = b;
    c.acc_op = op;
    return c;
  endfunction

  function automatic rfh_cmd_t upd(logic [2:0] u);
    rfh_cmd_t c;
    c     = CMD_NOP;
    c.upd = u;
    return c;
  endfunction

  assign step_full = state_r - ST_F0;
  assign step      = step_full[2:0];

  // Per-mode step program of the two-pole filter.
  always_comb begin
    filt_cmd  = CMD_NOP;
    filt_last = 1'b0;
    priority if (filter_mode == MODE_RES) begin
      unique case (step)
        3'd0: filt_cmd = mac(A_X, B_C, ACC_LOAD);
        3'd1: filt_cmd = mac(A_S1, B_C, ACC_SUB);
        3'd2: filt_cmd = mac(A_S1, B_RC, ACC_ADD);
        3'd3: filt_cmd = mac(A_S2, B_RC, ACC_SUB);
        3'd4: filt_cmd = upd(UPD_S1_ADD);
        3'd5: filt_cmd = mac(A_S1, B_C, ACC_LOAD);
        3'd6: filt_cmd = mac(A_S2, B_C, ACC_SUB);
        default: begin
          filt_cmd  = upd(UPD_S2_ADD);
          filt_last = 1'b1;
        end
      endcase
    end else if (filter_mode == MODE_SIMPLE) begin
      unique case (step)
        3'd0: filt_cmd = mac(A_S1, B_RC, ACC_LOAD);
        3'd1: filt_cmd = mac(A_S2, B_C, ACC_SUB);
        3'd2: filt_cmd = mac(A_X, B_C, ACC_ADD);
        3'd3: filt_cmd = upd(UPD_S1_SUB);
        3'd4: filt_cmd = mac(A_S2, B_RC, ACC_LOAD);
        3'd5: filt_cmd = mac(A_S1, B_C, ACC_ADD);
        3'd6: begin
          filt_cmd  = upd(UPD_S2_SUB);
          filt_last = 1'b1;
        end
        default: filt_last = 1'b1;
      endcase
    end else begin
      filt_cmd  = upd(UPD_S2_X);
      filt_last = 1'b1;
    end
  end

  always_comb begin
    cmd           = CMD_NOP;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_x = 1'b1;
          state_nxt  = ST_F0;
        end
      end
      ST_H0: begin
        cmd       = mac(A_S2, B_HPC, ACC_LOAD);
        state_nxt = ST_H1;
      end
      ST_H1: begin
        cmd       = mac(A_HP, B_HPINV, ACC_ADD);
        state_nxt = ST_H2;
      end
      ST_H2: begin
        cmd       = upd(UPD_HP);
        state_nxt = ST_G0;
      end
      ST_G0: begin
        cmd       = mac(A_DIFF, B_GAIN, ACC_LOAD);
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // The result register must be empty, or emptying this cycle.
        if (!out_valid_r || out_ready) begin
          cmd           = upd(UPD_OUT);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        if (state_r >= ST_F0 && state_r <= ST_F7) begin
          cmd       = filt_cmd;
          state_nxt = filt_last ? ST_H0 : state_r + 4'd1;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

[rtl/core/rfh_dpath.sv]
// Datapath with one shared multiplier, an accumulator and the filter state registers.
module rfh_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  rfh_pkg::rfh_cmd_t cmd,
  input  logic signed [7:0] in_sample_in,
  input  logic signed [7:0] coeff_c,
  input  logic signed [7:0] coeff_rc,
  input  logic [6:0]        hp_cutoff,
  input  logic [7:0]        amp_gain,
  output logic [7:0]        pwm_duty
);
  import rfh_pkg::*;

  logic signed [7:0]  x_r, x_nxt;
  logic signed [15:0] s1_r, s1_nxt;
  logic signed [15:0] s2_r, s2_nxt;
  logic signed [15:0] hp_r, hp_nxt;
  logic [15:0]        acc_r, acc_nxt;
  logic [7:0]         duty_r, duty_nxt;

  logic [15:0] a_val, b_val;
  logic [31:0] prod_full;
  logic [15:0] prod;
  logic signed [15:0] shifted;
  logic signed [15:0] s2_sum;
  logic [6:0]  hp_inv;
  logic [15:0] y_off;

  function automatic logic signed [15:0] clip127(logic signed [15:0] v);
    logic signed [15:0] r;
    r = v;
    if (v > CLIP_HIGH) r = CLIP_HIGH;
    else if (v < CLIP_LOW) r = CLIP_LOW;
    return r;
  endfunction

  assign hp_inv = 7'd127 - hp_cutoff;

  always_comb begin
    unique case (cmd.a_sel)
      A_X:     a_val = {{8{x_r[7]}}, x_r};
      A_S1:    a_val = s1_r;
      A_S2:    a_val = s2_r;
      A_HP:    a_val = hp_r;
      A_DIFF:  a_val = s2_r - hp_r;
      default: a_val = '0;
    endcase
    unique case (cmd.b_sel)
      B_C:     b_val = {{8{coeff_c[7]}}, coeff_c};
      B_RC:    b_val = {{8{coeff_rc[7]}}, coeff_rc};
      B_HPC:   b_val = {9'd0, hp_cutoff};
      B_HPINV: b_val = {9'd0, hp_inv};
      B_GAIN:  b_val = {8'd0, amp_gain};
      default: b_val = '0;
    endcase
  end

  // Only the low 16 bits matter: every product wraps as a 16-bit value.
  assign prod_full = a_val * b_val;
  assign prod      = prod_full[15:0];

  always_comb begin
    unique case (cmd.acc_op)
      ACC_LOAD: acc_nxt = prod;
      ACC_ADD:  acc_nxt = acc_r + prod;
      ACC_SUB:  acc_nxt = acc_r - prod;
      default:  acc_nxt = acc_r;
    endcase
  end

  assign shifted = $signed(acc_r) >>> FRAC_SHIFT;
  assign s2_sum  = (cmd.upd == UPD_S2_SUB) ? s2_r - shifted : s2_r + shifted;

  always_comb begin
    x_nxt    = cmd.load_x ? in_sample_in : x_r;
    s1_nxt   = s1_r;
    s2_nxt   = s2_r;
    hp_nxt   = hp_r;
    duty_nxt = duty_r;
    y_off    = clip127(shifted) + 16'd127;
    unique case (cmd.upd)
      UPD_S1_ADD: s1_nxt = s1_r + shifted;
      UPD_S1_SUB: s1_nxt = s1_r - shifted;
      UPD_S2_ADD,
      UPD_S2_SUB: s2_nxt = clip127(s2_sum);
      UPD_S2_X:   s2_nxt = clip127({{8{x_r[7]}}, x_r});
      UPD_HP:     hp_nxt = shifted;
      UPD_OUT:    duty_nxt = y_off[7:0];
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
      hp_r <= '0;
    end else begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      hp_r <= hp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    acc_r  <= acc_nxt;
    duty_r <= duty_nxt;
  end

  assign pwm_duty = duty_r;

endmodule

[rtl/core/resonant_filter_hpf_amp_chain.sv]
// Top level: configuration registers, sequencer and datapath of the filter chain.
//
// One transaction on the input channel carries a signed audio sample; one transaction on
// the output channel returns the matching PWM duty (0..254). Each sample runs a two-pole
// filter, a one-pole high-pass tracker and a gain stage through a single shared
// 16x16 multiplier and accumulator, at most one product per cycle.
// An input transaction is taken only while the sequencer is idle. Each sample then
// runs the filter steps of its mode, the high-pass steps, the gain step and the
// output step before the sequencer returns to idle; bypass has the fewest filter
// steps and the resonant form the most. The number of steps is set by the multiply
// steps each mode needs on the shared multiplier.
// The result sits in an output register, so the next sample is accepted and
// processed while it waits; if the receiver still stalls when the next result is
// ready, the sequencer holds in its final step until the register frees up.
// Configuration is a plain write port: cfg_wr_en with cfg_index 0..4 writes filter
// mode, cutoff, resonance, high-pass weight and gain; other indexes are ignored.
// Reset (synchronous, active low) clears the registers, filter state and tracker,
// and leaves no result pending.
module resonant_filter_hpf_amp_chain (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [7:0] in_sample_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_pwm_duty,
  input  logic              cfg_wr_en,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_wdata
);
  import rfh_pkg::*;

  logic [1:0]        filter_mode_r;
  logic signed [7:0] coeff_c_r;
  logic signed [7:0] coeff_rc_r;
  logic [6:0]        hp_cutoff_r;
  logic [7:0]        amp_gain_r;
  rfh_cmd_t          cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_mode_r <= MODE_BYPASS;
      coeff_c_r     <= '0;
      coeff_rc_r    <= '0;
      hp_cutoff_r   <= '0;
      amp_gain_r    <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FILTER_MODE: filter_mode_r <= cfg_wdata[1:0];
        CFG_COEFF_C:     coeff_c_r     <= cfg_wdata;
        CFG_COEFF_RC:    coeff_rc_r    <= cfg_wdata;
        CFG_HP_CUTOFF:   hp_cutoff_r   <= cfg_wdata[6:0];
        CFG_AMP_GAIN:    amp_gain_r    <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  rfh_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .filter_mode (filter_mode_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .cmd         (cmd)
  );

  rfh_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_sample_in (in_sample_in),
    .coeff_c      (coeff_c_r),
    .coeff_rc     (coeff_rc_r),
    .hp_cutoff    (hp_cutoff_r),
    .amp_gain     (amp_gain_r),
    .pwm_duty     (out_pwm_duty)
  );

  // After a transaction is taken the sequencer is busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in consecutive cycles");

  // A fresh result only appears at the end of a sequence, never straight from idle.
  a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result raised without a sample in flight");

  // The offset clipped output never exceeds 254.
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pwm_duty <= 8'd254)
    else $error("pwm duty out of range");

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the resonant filter, high-pass tracker and amplifier chain.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rfh_pkg::*;

  localparam logic [1:0] MODE_UNUSED    = 2'd3;
  localparam logic [2:0] CFG_LAST_INDEX = 3'd7;
  localparam int SETTLE_CYCLES          = 16;
  localparam int WATCHDOG_LIMIT         = 4000;
  localparam int RANDOM_PHASES          = 12;
  localparam int PHASE_SAMPLES          = 117;

  logic              clk;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic              in_ready;
  logic signed [7:0] in_sample_in = '0;
  logic              out_valid;
  logic              out_ready    = 1'b0;
  logic [7:0]        out_pwm_duty;
  logic              cfg_wr_en    = 1'b0;
  logic [2:0]        cfg_index    = '0;
  logic [7:0]        cfg_wdata    = '0;

  resonant_filter_hpf_amp_chain dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample_in (in_sample_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pwm_duty (out_pwm_duty),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Predictor copy of the registers and the filter state.
  logic [1:0]         flt_mode  = MODE_BYPASS;
  logic signed [7:0]  flt_c     = '0;
  logic signed [7:0]  flt_rc    = '0;
  logic [6:0]         flt_hpc   = '0;
  logic [7:0]         flt_gain  = '0;
  logic signed [15:0] st_one    = '0;
  logic signed [15:0] st_two    = '0;
  logic signed [15:0] st_track  = '0;

  logic [7:0] expected_duty[$];
  int err_count       = 0;
  int samples_sent    = 0;
  int duties_checked  = 0;
  int settings_used   = 0;
  int burst_left      = 0;
  int gap_max         = 0;
  int rx_stall_pct    = 0;
  int rx_hold_req     = 0;
  int rx_hold_left    = 0;
  int quiet_cycles    = 0;

  function automatic logic signed [15:0] clip_sym(input logic signed [15:0] v);
    if (v > CLIP_HIGH) return CLIP_HIGH;
    if (v < CLIP_LOW) return CLIP_LOW;
    return v;
  endfunction

  // All arithmetic is on signed 16-bit operands, so sums and products wrap at 2^16.
  function automatic logic [7:0] predict_duty(input logic signed [7:0] smp);
    logic signed [15:0] x, c, rc, w_new, w_old, g, acc, s1, s2, hp, diff, y;
    x = smp;
    c = flt_c;
    rc = flt_rc;
    w_new = $signed({9'd0, flt_hpc});
    w_old = CLIP_HIGH - w_new;
    g = $signed({8'd0, flt_gain});
    s1 = st_one;
    s2 = st_two;
    hp = st_track;
    case (flt_mode)
      MODE_RES: begin
        acc = x * c - s1 * c + s1 * rc - s2 * rc;
        s1 = s1 + (acc >>> FRAC_SHIFT);
        acc = s1 * c - s2 * c;
        s2 = s2 + (acc >>> FRAC_SHIFT);
      end
      MODE_SIMPLE: begin
        acc = s1 * rc - s2 * c + x * c;
        s1 = s1 - (acc >>> FRAC_SHIFT);
        acc = s2 * rc + s1 * c;
        s2 = s2 - (acc >>> FRAC_SHIFT);
      end
      default: begin
        s2 = x;
      end
    endcase
    s2 = clip_sym(s2);
    acc = s2 * w_new + hp * w_old;
    hp = acc >>> FRAC_SHIFT;
    diff = s2 - hp;
    acc = diff * g;
    y = clip_sym(acc >>> FRAC_SHIFT);
    st_one = s1;
    st_two = s2;
    st_track = hp;
    acc = y + CLIP_HIGH;
    return acc[7:0];
  endfunction

  function automatic logic [7:0] pick_coef();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 8'h7f : 8'h80;
      1: return 8'($urandom_range(255));
      default: return 8'($signed($urandom_range(80)) - 40);
    endcase
  endfunction

  function automatic logic [7:0] pick_weight(input logic [7:0] top);
    if ($urandom_range(3) == 0) return $urandom_range(1) ? top : 8'd0;
    return 8'($urandom_range(top));
  endfunction

  // Offers one sample and waits for its transaction; valid stays up inside a burst.
  task automatic send_sample(input logic signed [7:0] smp);
    in_valid <= 1'b1;
    in_sample_in <= smp;
    do @(posedge clk); while (!in_ready);
    expected_duty.push_back(predict_duty(smp));
    samples_sent++;
    if (gap_max != 0 && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(gap_max, 1)) @(posedge clk);
      burst_left = $urandom_range(12);
    end else if (burst_left != 0) begin
      burst_left--;
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_duty.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_FILTER_MODE: flt_mode = data[1:0];
      CFG_COEFF_C:     flt_c = data;
      CFG_COEFF_RC:    flt_rc = data;
      CFG_HP_CUTOFF:   flt_hpc = data[6:0];
      CFG_AMP_GAIN:    flt_gain = data;
      default: ;
    endcase
  endtask

  task automatic set_filter(input logic [1:0] mode, input logic [7:0] c, input logic [7:0] rc,
                            input logic [6:0] hpc, input logic [7:0] gain);
    drain_results();
    write_reg(CFG_FILTER_MODE, {6'd0, mode});
    write_reg(CFG_COEFF_C, c);
    write_reg(CFG_COEFF_RC, rc);
    write_reg(CFG_HP_CUTOFF, {1'b0, hpc});
    write_reg(CFG_AMP_GAIN, gain);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  task automatic test_mode_extremes();
    gap_max = 6;
    rx_stall_pct = 30;
    set_filter(MODE_BYPASS, 8'h00, 8'h00, 7'd0, 8'hff);
    send_sample(-8'sd128);
    send_sample(8'sd127);
    send_sample(-8'sd127);
    send_sample(8'sd0);
    set_filter(MODE_RES, 8'h7f, 8'h80, 7'd127, 8'h80);
    send_sample(8'sd127);
    send_sample(-8'sd128);
    send_sample(8'sh55);
    send_sample(8'shaa);
    set_filter(MODE_SIMPLE, 8'h80, 8'h7f, 7'd64, 8'hff);
    send_sample(8'sd127);
    send_sample(-8'sd128);
    send_sample(8'sd127);
    send_sample(-8'sd128);
    // The unused mode code must behave exactly like bypass.
    set_filter(MODE_UNUSED, 8'h40, 8'h40, 7'd1, 8'h01);
    send_sample(-8'sd128);
    send_sample(8'sd127);
    send_sample(8'sd42);
  endtask

  // Writes to indexes past the last register must leave every setting alone.
  task automatic test_unused_index();
    set_filter(MODE_RES, 8'h20, 8'h60, 7'd12, 8'hc0);
    drain_results();
    for (int idx = CFG_AMP_GAIN + 1; idx <= CFG_LAST_INDEX; idx++) begin
      write_reg(3'(idx), 8'hff);
    end
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    send_sample(8'sd100);
    send_sample(-8'sd90);
    send_sample(8'sd7);
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      gap_max = (p % 3 == 0) ? 0 : $urandom_range(16, 2);
      rx_stall_pct = (p % 3 == 1) ? 0 : $urandom_range(60, 10);
      set_filter(2'(p % 4), pick_coef(), pick_coef(), 7'(pick_weight(8'd127)),
                 pick_weight(8'd255));
      repeat (PHASE_SAMPLES) send_sample(8'($urandom_range(255)));
    end
  endtask

  // Long output stall while samples keep coming, so the block fills and stops taking input.
  task automatic test_backpressure();
    gap_max = 0;
    rx_stall_pct = 0;
    set_filter(MODE_RES, 8'd20, 8'd100, 7'd10, 8'd200);
    rx_hold_req = 400;
    repeat (30) send_sample(8'($urandom_range(255)));
    drain_results();
  endtask

  always @(posedge clk) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_duty.size() == 0) begin
        $error("pwm_duty: no result expected, actual %0d", out_pwm_duty);
        err_count++;
      end else begin
        logic [7:0] want;
        want = expected_duty.pop_front();
        if (out_pwm_duty !== want) begin
          $error("pwm_duty: expected %0d, actual %0d", want, out_pwm_duty);
          err_count++;
        end
        duties_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_mode_extremes();
    test_unused_index();
    test_random_settings();
    test_backpressure();
    drain_results();
    if (expected_duty.size() != 0) begin
      $error("pwm_duty: %0d results never arrived", expected_duty.size());
      err_count++;
    end
    $display("Ran %0d samples through %0d filter settings covering every mode and gain extreme,",
             samples_sent, settings_used);
    $display("with idle gaps, output stalls and a long backpressure hold; %0d duties checked.",
             duties_checked);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[resonant_filter_hpf_amp_chain.f]
rtl/core/rfh_pkg.sv
rtl/core/rfh_ctrl.sv
rtl/core/rfh_dpath.sv
rtl/core/resonant_filter_hpf_amp_chain.sv
tb/sv/tb_top.sv
